// ----- sv/keyboard_matrix_scan_core_defines.svh -----
// Assertion macros shared by the keyboard matrix scan core.
// Depends on nothing; included by the top level, which carries the concurrent assertions.
`ifndef KEYBOARD_MATRIX_SCAN_CORE_DEFINES_SVH
`define KEYBOARD_MATRIX_SCAN_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define KMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kms_pkg.sv -----
// Types and constants of the keyboard matrix scan core.
// Depends on nothing; used by the channel interface, the matrix and the top level.
package kms_pkg;

    // Command codes carried by an input word.
    typedef enum logic [2:0] {
        CMD_PRESS           = 3'd0,
        CMD_RELEASE         = 3'd1,
        CMD_TOGGLE          = 3'd2,
        CMD_SCAN_COLS       = 3'd3,
        CMD_SCAN_ROWS       = 3'd4,
        CMD_SET_LOCK        = 3'd5,
        CMD_RESTORE_PRESS   = 3'd6,
        CMD_RESTORE_RELEASE = 3'd7
    } t_command;

    // Position of the shift lock key and the idle matrix word.
    localparam logic [2:0] LOCK_ROW     = 3'd6;
    localparam logic [2:0] LOCK_COL     = 3'd4;
    localparam logic [7:0] ALL_RELEASED = 8'hFF;

    // One input word.
    typedef struct packed {
        t_command    command;
        logic [2:0]  key_row;
        logic [2:0]  key_col;
        logic [7:0]  scan_mask;
        logic        lock_value;
    } t_cmd_word;

    // One result word.
    typedef struct packed {
        logic [7:0]  scan_value;
        logic        nmi_low;
        logic        matrix_changed;
    } t_res_word;

endpackage

// ----- sv/kms_stream_if.sv -----
// Valid/ready channel that moves one word per handshake.
// Depends on kms_pkg for the default word type.
interface kms_stream_if #(
    parameter type T = kms_pkg::t_cmd_word
);
    logic valid;
    logic ready;
    T     data;

    // The producer drives valid and data, the consumer drives ready.
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/kms_matrix.sv -----
// Key matrix store, shift lock and restore state, with the command decode.
// Depends on kms_pkg; the result is combinational, the state updates on i_apply.
module kms_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_apply,
    input  kms_pkg::t_cmd_word i_word,
    output kms_pkg::t_res_word o_res
);
    import kms_pkg::*;

    logic [7:0] r_rows [8];
    logic       r_lock;
    logic       r_restore;

    logic [7:0] n_row;
    logic       n_lock;
    logic       n_restore;
    logic       s_row_write;

    logic [7:0] s_old_row;
    logic       s_old_bit;
    logic       s_is_lock_key;
    logic       s_press;
    logic       s_release;
    logic [7:0] s_scan_cols;
    logic [7:0] s_scan_rows;

    // The addressed row and key under the current command.
    assign s_old_row     = r_rows[i_word.key_row];
    assign s_old_bit     = s_old_row[i_word.key_col];
    assign s_is_lock_key = (i_word.key_row == LOCK_ROW) && (i_word.key_col == LOCK_COL);

    // Scan by columns: AND of the selected row words.
    always_comb begin
        s_scan_cols = ALL_RELEASED;
        for (int i = 0; i < 8; i++) begin
            s_scan_cols = s_scan_cols & (r_rows[i] | {8{~i_word.scan_mask[i]}});
        end
        if (r_lock && i_word.scan_mask[LOCK_ROW]) begin
            s_scan_cols[LOCK_COL] = 1'b0;
        end
    end

    // Scan by rows: bit r is the AND of row r over the selected columns.
    always_comb begin
        for (int r = 0; r < 8; r++) begin
            s_scan_rows[r] = &(r_rows[r] | ~i_word.scan_mask);
        end
        if (r_lock && i_word.scan_mask[LOCK_COL]) begin
            s_scan_rows[LOCK_ROW] = 1'b0;
        end
    end

    // Command decode: next state and the result word.
    always_comb begin
        s_press     = 1'b0;
        s_release   = 1'b0;
        n_lock      = r_lock;
        n_restore   = r_restore;
        o_res.scan_value = ALL_RELEASED;
        unique case (i_word.command)
            CMD_PRESS:           s_press = 1'b1;
            CMD_RELEASE:         s_release = 1'b1;
            CMD_TOGGLE: begin
                s_press   = s_old_bit;
                s_release = ~s_old_bit;
            end
            CMD_SCAN_COLS:       o_res.scan_value = s_scan_cols;
            CMD_SCAN_ROWS:       o_res.scan_value = s_scan_rows;
            CMD_SET_LOCK:        n_lock = i_word.lock_value;
            CMD_RESTORE_PRESS:   n_restore = 1'b1;
            CMD_RESTORE_RELEASE: n_restore = 1'b0;
            default:             n_restore = r_restore;
        endcase

        // A release of the shift lock key is ignored while the lock is held.
        n_row = s_old_row;
        if (s_press) begin
            n_row[i_word.key_col] = 1'b0;
        end else if (s_release && !(s_is_lock_key && r_lock)) begin
            n_row[i_word.key_col] = 1'b1;
        end
        s_row_write = s_press || s_release;

        o_res.nmi_low        = n_restore;
        o_res.matrix_changed = (n_row != s_old_row) || (n_lock != r_lock);
    end

    // State update when the word is handed on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_rows[i] <= ALL_RELEASED;
            end
            r_lock    <= 1'b0;
            r_restore <= 1'b0;
        end else if (i_apply) begin
            if (s_row_write) begin
                r_rows[i_word.key_row] <= n_row;
            end
            r_lock    <= n_lock;
            r_restore <= n_restore;
        end
    end

endmodule

// ----- sv/keyboard_matrix_scan_core.sv -----
// Top level of the keyboard matrix scan core: input register, matrix, result register.
// Depends on kms_pkg, kms_stream_if, kms_matrix and keyboard_matrix_scan_core_defines.svh.
//
// The core takes one command word per cycle while the result consumer keeps up, and
// gives one result word for each, in order. A word is first held in an input register;
// in the cycle it moves on, the key matrix decodes it, updates its state and loads the
// result register, from which the result is offered; the sustained rate is one word per
// clock when the consumer is ready. The input register and the result register each
// hold a word, so with the consumer stalled one further command is still taken before
// the input stops. Scans of rows and columns read the whole 8x8 store at once through a
// shallow AND of the selected rows or columns.
module keyboard_matrix_scan_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kms_stream_if.sink     i_cmd,
    kms_stream_if.source   o_res
);
    import kms_pkg::*;

`include "keyboard_matrix_scan_core_defines.svh"

    logic       r_in_valid;
    t_cmd_word  r_in;
    logic       r_out_valid;
    t_res_word  r_res;

    logic       s_advance;
    logic       s_out_free;
    t_res_word  s_res;

    // The result register is free when empty or being read this cycle.
    assign s_out_free = !r_out_valid || o_res.ready;
    assign s_advance  = r_in_valid && s_out_free;

    assign i_cmd.ready = !r_in_valid || s_out_free;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // Matrix state and command decode.
    kms_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (s_advance),
        .i_word  (r_in),
        .o_res   (s_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_res <= s_res;
        end
    end

    // A restore press always leaves the NMI line pulled low in its result.
    `KMS_ASSERT_NEXT(a_restore_nmi, i_clk, i_rst_n, s_advance && (r_in.command == CMD_RESTORE_PRESS), r_res.nmi_low, "restore press did not pull NMI low")
    // Scans never alter the matrix or the lock.
    `KMS_ASSERT_NEXT(a_scan_no_change, i_clk, i_rst_n, s_advance && ((r_in.command == CMD_SCAN_COLS) || (r_in.command == CMD_SCAN_ROWS)), !r_res.matrix_changed, "scan reported a change")
    // Commands other than scans answer with every key released.
    `KMS_ASSERT_NEXT(a_idle_scan_value, i_clk, i_rst_n, s_advance && (r_in.command != CMD_SCAN_COLS) && (r_in.command != CMD_SCAN_ROWS), r_res.scan_value == ALL_RELEASED, "non-scan command returned a scan value")

endmodule
